// ===== rtl/core/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

    // Hue circle segment, 0 starts at red.
    typedef enum logic [2:0] {
        SEG_RED_YEL = 3'd0,
        SEG_YEL_GRN = 3'd1,
        SEG_GRN_CYN = 3'd2,
        SEG_CYN_BLU = 3'd3,
        SEG_BLU_MAG = 3'd4,
        SEG_MAG_RED = 3'd5
    } seg_t;

    // Input mode carried on tuser.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_DEGREE = 1'b1;

    // Byte mode segment boundaries.
    localparam logic [7:0] BYTE_B1 = 8'd42;
    localparam logic [7:0] BYTE_B2 = 8'd85;
    localparam logic [7:0] BYTE_B3 = 8'd128;
    localparam logic [7:0] BYTE_B4 = 8'd170;
    localparam logic [7:0] BYTE_B5 = 8'd213;

    // Degree mode segment boundaries.
    localparam logic [8:0] DEG_B1 = 9'd60;
    localparam logic [8:0] DEG_B2 = 9'd120;
    localparam logic [8:0] DEG_B3 = 9'd180;
    localparam logic [8:0] DEG_B4 = 9'd240;
    localparam logic [8:0] DEG_B5 = 9'd300;

    // Percent clamp limit.
    localparam logic [7:0] PCT_MAX = 8'd100;

    // Modulo 360 by reciprocal: a multiple of 360 added makes the hue positive,
    // then floor(u / 360) = (u * RECIP_360) >> RECIP_SHIFT for all u < 2^17.
    localparam logic [16:0] HUE_BIAS    = 17'd33120;
    localparam logic [16:0] RECIP_360   = 17'd93207;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [8:0]  DEG_FULL    = 9'd360;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Segment and scaled operands handed from the hue path to the shading path.
    typedef struct packed {
        logic       grey;
        seg_t       seg;
        logic [7:0] delta;
        logic [7:0] sat;
        logic [7:0] val;
    } prep_out_t;

endpackage

// ===== rtl/core/hsvrgb_prep.sv =====
module hsvrgb_prep
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  kind,
    input  logic [15:0]           hue,
    input  logic [7:0]            saturation,
    input  logic [7:0]            brightness,
    output logic                  out_valid,
    output hsvrgb_pkg::prep_out_t out_data
);

    logic [3:0] valid_reg;

    // Stage 1 registers.
    logic        s1_kind_reg;
    logic [7:0]  s1_hbyte_reg;
    logic [16:0] s1_u_reg;
    logic [7:0]  s1_sat_reg;
    logic [7:0]  s1_val_reg;
    logic        s1_grey_reg;

    // Stage 2 registers.
    logic        s2_kind_reg;
    logic [7:0]  s2_hbyte_reg;
    logic [16:0] s2_u_reg;
    logic [7:0]  s2_quot_reg;
    logic [7:0]  s2_sat_reg;
    logic [7:0]  s2_val_reg;
    logic        s2_grey_reg;

    // Stage 3 registers.
    logic        s3_kind_reg;
    logic [7:0]  s3_hbyte_reg;
    logic [8:0]  s3_hdeg_reg;
    logic [7:0]  s3_sat_reg;
    logic [7:0]  s3_val_reg;
    logic        s3_grey_reg;

    // Stage 4 register.
    hsvrgb_pkg::prep_out_t s4_reg;

    logic [6:0]  sat_clamp;
    logic [6:0]  val_clamp;
    logic [7:0]  sat_next;
    logic [7:0]  val_next;
    logic        grey_next;
    logic [16:0] u_next;
    logic [33:0] quot_prod;
    logic [16:0] quot_mult;
    logic [16:0] rem_full;
    logic [8:0]  hdeg_next;

    logic [5:0]            boff;
    logic [5:0]            doff;
    hsvrgb_pkg::seg_t      bseg;
    hsvrgb_pkg::seg_t      dseg;
    logic [7:0]            bdelta;
    logic [7:0]            ddelta;
    hsvrgb_pkg::prep_out_t s4_next;

    // Valid bits advance with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Stage 1: clamp and scale percents, bias the hue positive.
    always_comb
    begin
        sat_clamp = (saturation > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX[6:0]
                                                       : saturation[6:0];
        val_clamp = (brightness > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX[6:0]
                                                       : brightness[6:0];
        if (kind == hsvrgb_pkg::KIND_DEGREE)
        begin
            sat_next  = {sat_clamp, 1'b0} + {2'b00, sat_clamp[6:1]};
            val_next  = {val_clamp, 1'b0} + {2'b00, val_clamp[6:1]};
            grey_next = (sat_clamp == 7'd0);
        end
        else
        begin
            sat_next  = saturation;
            val_next  = brightness;
            grey_next = (saturation == 8'd0);
        end
        u_next = {hue[15], hue} + hsvrgb_pkg::HUE_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= kind;
            s1_hbyte_reg <= hue[7:0];
            s1_u_reg     <= u_next;
            s1_sat_reg   <= sat_next;
            s1_val_reg   <= val_next;
            s1_grey_reg  <= grey_next;
        end
    end

    // Stage 2: quotient by 360 through the reciprocal multiply.
    assign quot_prod = {17'd0, s1_u_reg} * {17'd0, hsvrgb_pkg::RECIP_360};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_hbyte_reg <= s1_hbyte_reg;
            s2_u_reg     <= s1_u_reg;
            s2_quot_reg  <= quot_prod[hsvrgb_pkg::RECIP_SHIFT +: 8];
            s2_sat_reg   <= s1_sat_reg;
            s2_val_reg   <= s1_val_reg;
            s2_grey_reg  <= s1_grey_reg;
        end
    end

    // Stage 3: remainder gives the hue in 0..359.
    always_comb
    begin
        quot_mult = {9'd0, s2_quot_reg} * {8'd0, hsvrgb_pkg::DEG_FULL};
        rem_full  = s2_u_reg - quot_mult;
        hdeg_next = rem_full[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_hbyte_reg <= s2_hbyte_reg;
            s3_hdeg_reg  <= hdeg_next;
            s3_sat_reg   <= s2_sat_reg;
            s3_val_reg   <= s2_val_reg;
            s3_grey_reg  <= s2_grey_reg;
        end
    end

    // Stage 4: segment and in-segment offset for both modes.
    always_comb
    begin
        logic [7:0] bdiff;
        logic [8:0] ddiff;
        if (s3_hbyte_reg >= hsvrgb_pkg::BYTE_B5)
        begin
            bseg  = hsvrgb_pkg::SEG_MAG_RED;
            bdiff = s3_hbyte_reg - hsvrgb_pkg::BYTE_B5;
        end
        else if (s3_hbyte_reg >= hsvrgb_pkg::BYTE_B4)
        begin
            bseg  = hsvrgb_pkg::SEG_BLU_MAG;
            bdiff = s3_hbyte_reg - hsvrgb_pkg::BYTE_B4;
        end
        else if (s3_hbyte_reg >= hsvrgb_pkg::BYTE_B3)
        begin
            bseg  = hsvrgb_pkg::SEG_CYN_BLU;
            bdiff = s3_hbyte_reg - hsvrgb_pkg::BYTE_B3;
        end
        else if (s3_hbyte_reg >= hsvrgb_pkg::BYTE_B2)
        begin
            bseg  = hsvrgb_pkg::SEG_GRN_CYN;
            bdiff = s3_hbyte_reg - hsvrgb_pkg::BYTE_B2;
        end
        else if (s3_hbyte_reg >= hsvrgb_pkg::BYTE_B1)
        begin
            bseg  = hsvrgb_pkg::SEG_YEL_GRN;
            bdiff = s3_hbyte_reg - hsvrgb_pkg::BYTE_B1;
        end
        else
        begin
            bseg  = hsvrgb_pkg::SEG_RED_YEL;
            bdiff = s3_hbyte_reg;
        end
        boff   = bdiff[5:0];
        bdelta = {boff, 2'b00} + {1'b0, boff, 1'b0};

        if (s3_hdeg_reg >= hsvrgb_pkg::DEG_B5)
        begin
            dseg  = hsvrgb_pkg::SEG_MAG_RED;
            ddiff = s3_hdeg_reg - hsvrgb_pkg::DEG_B5;
        end
        else if (s3_hdeg_reg >= hsvrgb_pkg::DEG_B4)
        begin
            dseg  = hsvrgb_pkg::SEG_BLU_MAG;
            ddiff = s3_hdeg_reg - hsvrgb_pkg::DEG_B4;
        end
        else if (s3_hdeg_reg >= hsvrgb_pkg::DEG_B3)
        begin
            dseg  = hsvrgb_pkg::SEG_CYN_BLU;
            ddiff = s3_hdeg_reg - hsvrgb_pkg::DEG_B3;
        end
        else if (s3_hdeg_reg >= hsvrgb_pkg::DEG_B2)
        begin
            dseg  = hsvrgb_pkg::SEG_GRN_CYN;
            ddiff = s3_hdeg_reg - hsvrgb_pkg::DEG_B2;
        end
        else if (s3_hdeg_reg >= hsvrgb_pkg::DEG_B1)
        begin
            dseg  = hsvrgb_pkg::SEG_YEL_GRN;
            ddiff = s3_hdeg_reg - hsvrgb_pkg::DEG_B1;
        end
        else
        begin
            dseg  = hsvrgb_pkg::SEG_RED_YEL;
            ddiff = s3_hdeg_reg;
        end
        doff   = ddiff[5:0];
        ddelta = {doff, 2'b00} + {4'd0, doff[5:2]};

        s4_next.grey = s3_grey_reg;
        s4_next.sat  = s3_sat_reg;
        s4_next.val  = s3_val_reg;
        if (s3_kind_reg == hsvrgb_pkg::KIND_DEGREE)
        begin
            s4_next.seg   = dseg;
            s4_next.delta = ddelta;
        end
        else
        begin
            s4_next.seg   = bseg;
            s4_next.delta = bdelta;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = s4_reg;

endmodule

// ===== rtl/core/hsvrgb_shade.sv =====
module hsvrgb_shade
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  hsvrgb_pkg::prep_out_t in_data,
    output logic                  out_valid,
    output logic [11:0]           color
);

    logic [2:0] valid_reg;

    // Stage A: scaled complements of the saturation terms.
    logic             sa_grey_reg;
    hsvrgb_pkg::seg_t sa_seg_reg;
    logic [7:0]       sa_val_reg;
    logic [7:0]       sa_xp_reg;
    logic [7:0]       sa_xq_reg;
    logic [7:0]       sa_xt_reg;

    // Stage B: channel levels.
    logic             sb_grey_reg;
    hsvrgb_pkg::seg_t sb_seg_reg;
    logic [3:0]       sb_p_reg;
    logic [3:0]       sb_q_reg;
    logic [3:0]       sb_t_reg;
    logic [3:0]       sb_w_reg;

    // Stage C: packed colour.
    logic [11:0] sc_color_reg;
    logic [11:0] sc_color_next;

    logic [15:0] sd_prod;
    logic [15:0] sn_prod;
    logic [7:0]  delta_inv;
    logic [15:0] p_prod;
    logic [15:0] q_prod;
    logic [15:0] t_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Stage A: s*delta and s*(255-delta), both scaled down by 256.
    always_comb
    begin
        delta_inv = hsvrgb_pkg::FULL_SCALE - in_data.delta;
        sd_prod   = {8'd0, in_data.sat} * {8'd0, in_data.delta};
        sn_prod   = {8'd0, in_data.sat} * {8'd0, delta_inv};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_grey_reg <= in_data.grey;
            sa_seg_reg  <= in_data.seg;
            sa_val_reg  <= in_data.val;
            sa_xp_reg   <= hsvrgb_pkg::FULL_SCALE - in_data.sat;
            sa_xq_reg   <= hsvrgb_pkg::FULL_SCALE - sd_prod[15:8];
            sa_xt_reg   <= hsvrgb_pkg::FULL_SCALE - sn_prod[15:8];
        end
    end

    // Stage B: p, q and t levels, each product scaled down by 4096.
    always_comb
    begin
        p_prod = {8'd0, sa_val_reg} * {8'd0, sa_xp_reg};
        q_prod = {8'd0, sa_val_reg} * {8'd0, sa_xq_reg};
        t_prod = {8'd0, sa_val_reg} * {8'd0, sa_xt_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_grey_reg <= sa_grey_reg;
            sb_seg_reg  <= sa_seg_reg;
            sb_p_reg    <= p_prod[15:12];
            sb_q_reg    <= q_prod[15:12];
            sb_t_reg    <= t_prod[15:12];
            sb_w_reg    <= sa_val_reg[7:4];
        end
    end

    // Stage C: route levels to red, green and blue by segment.
    always_comb
    begin
        if (sb_grey_reg)
        begin
            sc_color_next = {sb_w_reg, sb_w_reg, sb_w_reg};
        end
        else
        begin
            unique case (sb_seg_reg)
                hsvrgb_pkg::SEG_RED_YEL: sc_color_next = {sb_w_reg, sb_t_reg, sb_p_reg};
                hsvrgb_pkg::SEG_YEL_GRN: sc_color_next = {sb_q_reg, sb_w_reg, sb_p_reg};
                hsvrgb_pkg::SEG_GRN_CYN: sc_color_next = {sb_p_reg, sb_w_reg, sb_t_reg};
                hsvrgb_pkg::SEG_CYN_BLU: sc_color_next = {sb_p_reg, sb_q_reg, sb_w_reg};
                hsvrgb_pkg::SEG_BLU_MAG: sc_color_next = {sb_t_reg, sb_p_reg, sb_w_reg};
                default:                 sc_color_next = {sb_w_reg, sb_p_reg, sb_q_reg};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_color_reg <= sc_color_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign color     = sc_color_reg;

endmodule

// ===== rtl/core/hsv_to_rgb444_convert.sv =====
// HSV to RGB444 converter. Each item on the slave stream carries a hue,
// saturation and value triple plus a mode flag on tuser: byte mode takes all
// three on a 0..255 scale, degree mode takes any signed hue in degrees (reduced
// modulo 360) with saturation and value in percent, clamped to 100. Each item
// yields one 12-bit colour with red in bits 11:8, green in 7:4 and blue in 3:0.
// The block accepts one item every clock cycle while the master side does not stall;
// each result passes through four pipeline stages of hue reduction and segment
// lookup, then three of shading. When the master side stalls, the whole pipeline
// holds and nothing is lost.
module hsv_to_rgb444_convert
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue [15:0], saturation [23:16], brightness [31:24]
    input  logic        s_tuser,   // kind [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // color [11:0], zero [15:12]
);

    logic                  en;
    logic                  prep_valid;
    hsvrgb_pkg::prep_out_t prep_data;
    logic                  shade_valid;
    logic [11:0]           shade_color;

    // The pipeline moves whenever its last stage is empty or being taken.
    assign en       = !shade_valid || m_tready;
    assign s_tready = en;

    hsvrgb_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .kind       (s_tuser),
        .hue        (s_tdata[15:0]),
        .saturation (s_tdata[23:16]),
        .brightness (s_tdata[31:24]),
        .out_valid  (prep_valid),
        .out_data   (prep_data)
    );

    hsvrgb_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (shade_valid),
        .color     (shade_color)
    );

    assign m_tvalid = shade_valid;
    assign m_tdata  = {4'd0, shade_color};

endmodule

// ===== verif/hsv_to_rgb444_convert_tb.sv =====
module hsv_to_rgb444_convert_tb;
    import hsvrgb_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 200;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    // One row of the directed stimulus; a typed color is used only when known is set.
    typedef struct packed {
        logic        kind;
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  bri;
        logic        known;
        logic [11:0] color;
    } hsv_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // hue [15:0], saturation [23:16], brightness [31:24]
    logic        s_tuser;   // kind [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // color [11:0], zero [15:12]

    logic [11:0] expected_colors[$];
    int          mismatch_count;
    int          quiet_cycles;
    logic        bursts_on;
    hsv_row_t    directed_rows[25];

    hsv_to_rgb444_convert dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Expected 12-bit color for one HSV triple.
    function automatic logic [11:0] predict_color(logic kind, logic [15:0] hue,
                                                  logic [7:0] sat, logic [7:0] bri);
        int unsigned full;
        int unsigned v;
        int unsigned s;
        int unsigned h;
        int unsigned delta;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        int unsigned w;
        int          hs;
        int          m;
        seg_t        seg;
        logic [3:0]  r;
        logic [3:0]  g;
        logic [3:0]  b;
        full = {24'd0, FULL_SCALE};
        v = {24'd0, bri};
        s = {24'd0, sat};
        if (kind == KIND_DEGREE)
        begin
            // Percent inputs are clamped, then scaled to 0..250.
            if (s > PCT_MAX)
                s = {24'd0, PCT_MAX};
            if (v > PCT_MAX)
                v = {24'd0, PCT_MAX};
            v = 2 * v + v / 2;
        end
        // No saturation means grey on all three channels.
        if (s == 0)
        begin
            w = v >> 4;
            return {w[3:0], w[3:0], w[3:0]};
        end
        if (kind == KIND_BYTE)
        begin
            h = {24'd0, hue[7:0]};
            if (h >= BYTE_B5)
            begin
                seg = SEG_MAG_RED;
                delta = 6 * (h - BYTE_B5);
            end
            else if (h >= BYTE_B4)
            begin
                seg = SEG_BLU_MAG;
                delta = 6 * (h - BYTE_B4);
            end
            else if (h >= BYTE_B3)
            begin
                seg = SEG_CYN_BLU;
                delta = 6 * (h - BYTE_B3);
            end
            else if (h >= BYTE_B2)
            begin
                seg = SEG_GRN_CYN;
                delta = 6 * (h - BYTE_B2);
            end
            else if (h >= BYTE_B1)
            begin
                seg = SEG_YEL_GRN;
                delta = 6 * (h - BYTE_B1);
            end
            else
            begin
                seg = SEG_RED_YEL;
                delta = 6 * h;
            end
        end
        else
        begin
            s = 2 * s + s / 2;
            // Signed hue wrapped into 0..359.
            hs = int'($signed(hue));
            m = hs % int'(DEG_FULL);
            if (m < 0)
                m = m + int'(DEG_FULL);
            h = m;
            if (h >= DEG_B5)
            begin
                seg = SEG_MAG_RED;
                h = h - DEG_B5;
            end
            else if (h >= DEG_B4)
            begin
                seg = SEG_BLU_MAG;
                h = h - DEG_B4;
            end
            else if (h >= DEG_B3)
            begin
                seg = SEG_CYN_BLU;
                h = h - DEG_B3;
            end
            else if (h >= DEG_B2)
            begin
                seg = SEG_GRN_CYN;
                h = h - DEG_B2;
            end
            else if (h >= DEG_B1)
            begin
                seg = SEG_YEL_GRN;
                h = h - DEG_B1;
            end
            else
            begin
                seg = SEG_RED_YEL;
            end
            delta = 4 * h + h / 4;
        end
        p = (v * (full - s)) >> 12;
        q = (v * (full - ((s * delta) >> 8))) >> 12;
        t = (v * (full - ((s * (full - delta)) >> 8))) >> 12;
        w = v >> 4;
        case (seg)
            SEG_RED_YEL: {r, g, b} = {w[3:0], t[3:0], p[3:0]};
            SEG_YEL_GRN: {r, g, b} = {q[3:0], w[3:0], p[3:0]};
            SEG_GRN_CYN: {r, g, b} = {p[3:0], w[3:0], t[3:0]};
            SEG_CYN_BLU: {r, g, b} = {p[3:0], q[3:0], w[3:0]};
            SEG_BLU_MAG: {r, g, b} = {t[3:0], p[3:0], w[3:0]};
            default:     {r, g, b} = {w[3:0], p[3:0], q[3:0]};
        endcase
        return {r, g, b};
    endfunction

    // Offer one item, with an occasional idle burst ahead of it, and record its color.
    task automatic send_hsv(logic kind, logic [15:0] hue, logic [7:0] sat,
                            logic [7:0] bri, logic [11:0] color);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {bri, sat, hue};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_colors.push_back(color);
        @(negedge clk);
    endtask

    // Hold the input side until every pending color has come out.
    task automatic drain_colors();
        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Random HSV triple, biased toward segment edges, grey and clamp cases.
    task automatic send_random_hsv();
        logic        kind;
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  bri;
        int          pick;
        int          edge_hues[12];
        edge_hues = '{0, 41, 42, 84, 85, 127, 128, 169, 170, 212, 213, 255};
        kind = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            hue = 16'($urandom);
        else if (pick < 7)
            hue = (kind == KIND_DEGREE) ? 16'($urandom_range(0, 359))
                                        : 16'($urandom_range(0, 255));
        else if (pick < 8 && kind == KIND_BYTE)
            hue = 16'(edge_hues[$urandom_range(0, 11)]);
        else if (pick < 8)
            hue = 16'(60 * $urandom_range(0, 6) - $urandom_range(0, 1));
        else
            hue = 16'(int'($urandom_range(0, 1440)) - 720);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            sat = 8'd0;
        else if (pick == 1)
            sat = ($urandom_range(0, 1) == 0) ? FULL_SCALE : PCT_MAX;
        else if (kind == KIND_DEGREE && pick < 7)
            sat = 8'($urandom_range(0, 110));
        else
            sat = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            bri = ($urandom_range(0, 1) == 0) ? FULL_SCALE : PCT_MAX;
        else if (kind == KIND_DEGREE && pick < 7)
            bri = 8'($urandom_range(0, 110));
        else
            bri = 8'($urandom);
        send_hsv(kind, hue, sat, bri, predict_color(kind, hue, sat, bri));
    endtask

    // Receiver back-pressure in short random bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each delivered color with the oldest pending one.
    always @(posedge clk)
    begin
        logic [11:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("color: no item pending, actual %h", m_tdata[11:0]);
                mismatch_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (m_tdata[11:0] !== want)
                begin
                    $error("color: expected %h, actual %h", want, m_tdata[11:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed rows, then random items.
    initial
    begin
        logic [11:0] want;
        mismatch_count = 0;
        quiet_cycles   = 0;
        bursts_on      = 1'b1;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_BYTE;

        directed_rows = '{
            '{KIND_BYTE,   16'd0,     8'd0,   8'd0,   1'b1, 12'h000},
            '{KIND_BYTE,   16'd0,     8'd0,   8'd255, 1'b1, 12'hFFF},
            '{KIND_BYTE,   16'd0,     8'd255, 8'd255, 1'b1, 12'hF00},
            '{KIND_BYTE,   16'd41,    8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd42,    8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd85,    8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd128,   8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd170,   8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd213,   8'd255, 8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd255,   8'd1,   8'd255, 1'b0, 12'h000},
            '{KIND_BYTE,   16'hFF2A,  8'd200, 8'd200, 1'b0, 12'h000},
            '{KIND_BYTE,   16'd127,   8'd128, 8'd1,   1'b0, 12'h000},
            '{KIND_DEGREE, 16'd0,     8'd0,   8'd100, 1'b1, 12'hFFF},
            '{KIND_DEGREE, 16'd0,     8'd0,   8'd255, 1'b1, 12'hFFF},
            '{KIND_DEGREE, 16'd120,   8'd100, 8'd100, 1'b1, 12'h0F0},
            '{KIND_DEGREE, 16'd240,   8'd255, 8'd255, 1'b1, 12'h00F},
            '{KIND_DEGREE, 16'hFF88,  8'd100, 8'd100, 1'b1, 12'h00F},
            '{KIND_DEGREE, 16'd360,   8'd100, 8'd100, 1'b1, 12'hF00},
            '{KIND_DEGREE, 16'h8000,  8'd50,  8'd70,  1'b0, 12'h000},
            '{KIND_DEGREE, 16'h7FFF,  8'd101, 8'd99,  1'b0, 12'h000},
            '{KIND_DEGREE, 16'd359,   8'd100, 8'd100, 1'b0, 12'h000},
            '{KIND_DEGREE, 16'd59,    8'd100, 8'd100, 1'b0, 12'h000},
            '{KIND_DEGREE, 16'd60,    8'd1,   8'd1,   1'b0, 12'h000},
            '{KIND_DEGREE, 16'd180,   8'd100, 8'd100, 1'b0, 12'h000},
            '{KIND_DEGREE, 16'd300,   8'd100, 8'd100, 1'b0, 12'h000}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].known)
                want = directed_rows[i].color;
            else
                want = predict_color(directed_rows[i].kind, directed_rows[i].hue,
                                     directed_rows[i].sat, directed_rows[i].bri);
            send_hsv(directed_rows[i].kind, directed_rows[i].hue,
                     directed_rows[i].sat, directed_rows[i].bri, want);
        end
        drain_colors();

        // Random items; the pipeline is emptied now and then, and the tail runs at full rate.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                bursts_on = 1'b0;
            if (n % 600 == 599)
                drain_colors();
            send_random_hsv();
        end

        s_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
